/* sv/sil_pkg.sv */
package sil_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_DUMP   = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_ELEMENT  = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_DUMP = 1'b1
   } state_type;

   // broadcast to every cell
   typedef struct packed {
      logic               insert;
      logic               rotate;
      logic signed [31:0] value;
   } cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic               valid;
      logic               lt;
      logic signed [31:0] value;
   } link_type;

endpackage

/* sv/sil_if.sv */
interface sil_req_if (input logic clock);
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sil_rsp_if (input logic clock);
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] element;
   logic               last;

   modport source (output valid, output status, output element, output last, input ready);
   modport sink   (input valid, input status, input element, input last, output ready);
endinterface

/* sv/sil_cell.sv */
module sil_cell (
   input  logic               clock,
   input  logic               reset,
   input  sil_pkg::cmd_type   cmd,
   input  sil_pkg::link_type  left,
   input  sil_pkg::link_type  right,
   input  logic signed [31:0] head_value,
   output sil_pkg::link_type  link
);

   logic               valid_ff, valid_in;
   logic signed [31:0] value_ff, value_in;
   logic               lt;

   assign lt = valid_ff && (value_ff < cmd.value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.insert) begin
         if (!lt) begin
            if (left.lt) begin
               valid_in = 1'b1;
               value_in = cmd.value;
            end else begin
               valid_in = left.valid;
               value_in = left.value;
            end
         end
      end else if (cmd.rotate && valid_ff) begin
         // last valid cell wraps around to the head
         value_in = right.valid ? right.value : head_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign link.valid = valid_ff;
   assign link.lt    = lt;
   assign link.value = value_ff;

endmodule

/* sv/sil_chain.sv */
module sil_chain (
   input  logic               clock,
   input  logic               reset,
   input  sil_pkg::cmd_type   cmd,
   output logic signed [31:0] head_value,
   output logic               full,
   output logic               empty
);

   sil_pkg::link_type links [sil_pkg::CAPACITY];
   sil_pkg::link_type edge_left;
   sil_pkg::link_type edge_right;

   // cell 0 always sees a "smaller" neighbor so a new minimum lands there
   assign edge_left.valid  = 1'b0;
   assign edge_left.lt     = 1'b1;
   assign edge_left.value  = '0;
   assign edge_right.valid = 1'b0;
   assign edge_right.lt    = 1'b0;
   assign edge_right.value = '0;

   for (genvar i = 0; i < sil_pkg::CAPACITY; i++) begin : g_cell
      sil_pkg::link_type left_l;
      sil_pkg::link_type right_l;

      if (i == 0) begin : g_first
         assign left_l = edge_left;
      end else begin : g_mid_l
         assign left_l = links[i-1];
      end

      if (i == sil_pkg::CAPACITY - 1) begin : g_last
         assign right_l = edge_right;
      end else begin : g_mid_r
         assign right_l = links[i+1];
      end

      sil_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left       (left_l),
         .right      (right_l),
         .head_value (head_value),
         .link       (links[i])
      );
   end

   assign head_value = links[0].value;
   assign full       = links[sil_pkg::CAPACITY-1].valid;
   assign empty      = !links[0].valid;

endmodule

/* sv/sorted_insertion_list.sv */
// Sorted insertion list: holds up to CAPACITY signed 32-bit values in ascending
// order in a chain of compare-and-shift cells. An insert request compares its
// value against every cell at once; cells holding smaller values keep them,
// the first cell that is not smaller takes the new value and every cell after
// it takes its left neighbor's value, so a new value goes ahead of equal ones.
// An insert into a full list is rejected with a full status. A dump request
// first enters the dump state and then streams one element per cycle, while
// the result register is free or being drained, from the head cell as the
// valid cells rotate toward the head; after n rotations the list is back in
// place. A dump of an empty list gets an empty status without entering the
// dump state. A new request is taken once the result register is free or
// being drained in the same cycle, and not during a dump.
module sorted_insertion_list (
   input  logic      clock,
   input  logic      reset,
   sil_req_if.sink   req_chan,
   sil_rsp_if.source rsp_chan
);

   sil_pkg::state_type state_ff, state_in;
   logic [sil_pkg::CNT_W-1:0] count_ff, count_in;
   logic [sil_pkg::CNT_W-1:0] dump_idx_ff, dump_idx_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   sil_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic signed [31:0]     rsp_element_ff, rsp_element_in;
   logic                   rsp_last_ff, rsp_last_in;

   sil_pkg::cmd_type   cmd;
   logic signed [31:0] head_value;
   logic               full;
   logic               empty;
   logic               out_free;
   logic               req_fire;
   logic               emit;

   sil_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .head_value (head_value),
      .full       (full),
      .empty      (empty)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == sil_pkg::S_IDLE) && out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dump_idx_in    = dump_idx_ff;
      emit           = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      cmd.insert     = 1'b0;
      cmd.rotate     = 1'b0;
      cmd.value      = req_chan.value;

      unique case (state_ff)
         sil_pkg::S_IDLE: begin
            if (req_fire) begin
               if (sil_pkg::kind_type'(req_chan.kind) == sil_pkg::KIND_INSERT) begin
                  emit           = 1'b1;
                  rsp_element_in = '0;
                  rsp_last_in    = 1'b1;
                  if (full) begin
                     rsp_status_in = sil_pkg::ST_FULL;
                  end else begin
                     rsp_status_in = sil_pkg::ST_INSERTED;
                     cmd.insert    = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end else if (empty) begin
                  emit           = 1'b1;
                  rsp_status_in  = sil_pkg::ST_EMPTY;
                  rsp_element_in = '0;
                  rsp_last_in    = 1'b1;
               end else begin
                  state_in    = sil_pkg::S_DUMP;
                  dump_idx_in = '0;
               end
            end
         end
         sil_pkg::S_DUMP: begin
            if (out_free) begin
               // head cell holds the next element; rotate brings the following one up
               emit           = 1'b1;
               cmd.rotate     = 1'b1;
               rsp_status_in  = sil_pkg::ST_ELEMENT;
               rsp_element_in = head_value;
               rsp_last_in    = (dump_idx_ff == sil_pkg::CNT_W'(count_ff - 1'b1));
               dump_idx_in    = dump_idx_ff + 1'b1;
               if (rsp_last_in) begin
                  state_in = sil_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = sil_pkg::S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sil_pkg::S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.element = rsp_element_ff;
   assign rsp_chan.last    = rsp_last_ff;

endmodule

/* bench/tb_sorted_insertion_list.sv */
`timescale 1ns / 1ps

module tb_sorted_insertion_list;

   // Cycles with no request or response moving before the run is declared hung.
   // Worst legal quiet stretch is the long response hold plus a sender gap.
   localparam int HANG_LIMIT = 1000;
   localparam int RANDOM_REQS = 155;
   localparam int LONG_HOLD = 150;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;

   sil_req_if req_bus (clock);
   sil_rsp_if rsp_bus (clock);

   sorted_insertion_list u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // One response as the list should produce it.
   typedef struct {
      sil_pkg::status_type status;
      logic signed [31:0]  element;
      logic                last;
   } reply_type;

   // Shadow of the sorted store plus the queue of responses still owed.
   class list_scoreboard;
      logic signed [31:0] held[$];     // ascending, mirrors the cell chain
      reply_type          owed[$];
      int                 failures;

      function void owe(sil_pkg::status_type status, logic signed [31:0] element,
                        logic last);
         reply_type r;
         r.status  = status;
         r.element = element;
         r.last    = last;
         owed.push_back(r);
      endfunction

      // Called once per accepted request, in acceptance order.
      function void note_request(sil_pkg::kind_type kind, logic signed [31:0] value);
         int pos;
         if (kind == sil_pkg::KIND_INSERT) begin
            if (held.size() >= sil_pkg::CAPACITY) begin
               owe(sil_pkg::ST_FULL, 32'sd0, 1'b1);
            end else begin
               // new value lands ahead of any equal values already held
               pos = 0;
               while (pos < held.size() && held[pos] < value)
                  pos++;
               held.insert(pos, value);
               owe(sil_pkg::ST_INSERTED, 32'sd0, 1'b1);
            end
         end else if (held.size() == 0) begin
            owe(sil_pkg::ST_EMPTY, 32'sd0, 1'b1);
         end else begin
            foreach (held[i])
               owe(sil_pkg::ST_ELEMENT, held[i], i == held.size() - 1);
         end
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10)
            $display("[%0t] %s", $realtime, msg);
      endfunction

      function void check_response(logic [1:0] status, logic signed [31:0] element,
                                   logic last);
         reply_type exp;
         if (owed.size() == 0) begin
            flag($sformatf("unexpected response: status %0d element %0d last %0d",
                           status, element, last));
            return;
         end
         exp = owed.pop_front();
         if (status !== exp.status || element !== exp.element || last !== exp.last)
            flag($sformatf("response exp status %0d element %0d last %0d, got %0d %0d %0d",
                           exp.status, exp.element, exp.last, status, element, last));
      endfunction

      function int outstanding();
         return owed.size();
      endfunction
   endclass

   list_scoreboard board = new();

   bit started  = 1'b0;   // reset done, sides may start
   bit no_idle  = 1'b0;   // burst stretch: neither side inserts gaps
   bit hold_rsp = 1'b0;   // asks the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap drawn per request/response; zero throughout a burst stretch.
   function automatic int pick_gap();
      if (no_idle)
         return 0;
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
   endfunction

   // Mix of extremes, a narrow band that produces ties, and full-range values.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         1: return $signed($urandom_range(0, 20)) - 32'sd10;
         default: return $signed($urandom());
      endcase
   endfunction

   // Offer one request after a random gap; valid stays up across back-to-back
   // requests so it never drops and rises in the same step.
   task automatic offer_request(input sil_pkg::kind_type kind,
                                input logic signed [31:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      do
         @(posedge clock);
      while (!(req_bus.valid && req_bus.ready));
      board.note_request(sil_pkg::kind_type'(req_bus.kind), req_bus.value);
   endtask

   // Response side: random stalls, plus one long hold-off on request so the
   // result register backs up and the request side stalls.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      wait (started);
      forever begin
         stall = pick_gap();
         if (hold_rsp) begin
            stall    = LONG_HOLD;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do
            @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready));
         board.check_response(rsp_bus.status, rsp_bus.element, rsp_bus.last);
      end
   end

   // Hang detector: counts edges where neither channel moves.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("sorted_insertion_list: mismatch");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= sil_pkg::KIND_INSERT;
      req_bus.value <= 32'sd0;
      repeat (2) @(posedge clock);
      reset   <= 1'b0;
      started  = 1'b1;

      // Directed: empty dump, single-entry dump, both extremes, ties at the
      // extremes and in the middle, dumps in between.
      offer_request(sil_pkg::KIND_DUMP,   32'sd0);
      offer_request(sil_pkg::KIND_INSERT, 32'sh7fff_ffff);
      offer_request(sil_pkg::KIND_DUMP,   -32'sd1);
      offer_request(sil_pkg::KIND_INSERT, 32'sh8000_0000);
      offer_request(sil_pkg::KIND_INSERT, 32'sd0);
      offer_request(sil_pkg::KIND_INSERT, -32'sd1);
      offer_request(sil_pkg::KIND_INSERT, 32'sd1);
      offer_request(sil_pkg::KIND_INSERT, 32'sd7);
      offer_request(sil_pkg::KIND_INSERT, 32'sd7);
      offer_request(sil_pkg::KIND_INSERT, -32'sd7);
      offer_request(sil_pkg::KIND_DUMP,   32'sh5555_aaaa);
      offer_request(sil_pkg::KIND_INSERT, 32'sh8000_0000);
      offer_request(sil_pkg::KIND_INSERT, 32'sh7fff_ffff);
      offer_request(sil_pkg::KIND_INSERT, 32'sd0);
      offer_request(sil_pkg::KIND_DUMP,   32'sd0);

      // Random: mostly inserts so the list fills and then sits full, where
      // inserts bounce and each dump streams the whole store.
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 30 == 0)
            no_idle = ($urandom_range(0, 2) == 0);
         if (n == 10 || n == 120)
            hold_rsp = 1'b1;
         if ($urandom_range(0, 4) == 0)
            offer_request(sil_pkg::KIND_DUMP, $signed($urandom()));
         else
            offer_request(sil_pkg::KIND_INSERT, pick_value());
      end
      req_bus.valid <= 1'b0;

      while (board.outstanding() > 0)
         @(posedge clock);
      // catch any stray response after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.outstanding() == 0)
         $display("sorted_insertion_list: match");
      else
         $display("sorted_insertion_list: mismatch");
      $finish;
   end

endmodule
